// File: hw/rtl/sjd_pkg.sv
// ----------------------------------------------------------------------------
// sjd_pkg
// Shared types, constants and helpers of the Shift-JIS to UTF-16 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sjd_pkg;

    // field widths
    localparam int COUNT_W = 21;
    localparam int BYTE_W  = 8;
    localparam int KEY_W   = 16;
    localparam int UNIT_W  = 16;
    localparam int ENTRY_W = UNIT_W + 1;

    // item kinds
    typedef enum logic {
        OP_CONVERT = 1'b0,
        OP_LOAD    = 1'b1
    } t_op;

    // lead byte ranges
    localparam logic [BYTE_W-1:0] LEAD_A_LO = 8'h81;
    localparam logic [BYTE_W-1:0] LEAD_A_HI = 8'h9F;
    localparam logic [BYTE_W-1:0] LEAD_B_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_B_HI = 8'hFC;

    // white square for unmapped codes
    localparam logic [UNIT_W-1:0] UNKNOWN_UNIT = 16'h25A1;

    // buffer size after reset and bytes reserved for the terminator
    localparam logic [COUNT_W-1:0] BUF_RESET  = 21'h100000;
    localparam logic [COUNT_W-1:0] UNIT_BYTES = 21'd2;

    function automatic logic is_lead(input logic [BYTE_W-1:0] b);
        return ((b >= LEAD_A_LO) && (b <= LEAD_A_HI)) ||
               ((b >= LEAD_B_LO) && (b <= LEAD_B_HI));
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sjd_if.sv
// ----------------------------------------------------------------------------
// sjd_if
// Valid/ready channels of the decoder: byte and load words in, code units out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjd_in_if import sjd_pkg::*;;
    logic              valid;
    logic              ready;
    t_op               operation;
    logic [BYTE_W-1:0] in_byte;
    logic [KEY_W-1:0]  map_key;
    logic [UNIT_W-1:0] map_value;

    modport source (output valid, output operation, output in_byte,
                    output map_key, output map_value, input ready);
    modport sink   (input valid, input operation, input in_byte,
                    input map_key, input map_value, output ready);
endinterface

interface sjd_out_if import sjd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [UNIT_W-1:0]  code_unit;
    logic               last;
    logic [COUNT_W-1:0] byte_count;
    logic               truncated;

    modport source (output valid, output code_unit, output last,
                    output byte_count, output truncated, input ready);
    modport sink   (input valid, input code_unit, input last,
                    input byte_count, input truncated, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sjd_ram.sv
// ----------------------------------------------------------------------------
// sjd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sjd_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 17
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/sjis_to_utf16_decoder_core.sv
// ----------------------------------------------------------------------------
// sjis_to_utf16_decoder_core
// Shift-JIS byte stream to UTF-16 code units through a loadable 64K map RAM.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   operation, in_byte, map_key, map_value
//  o_out     out  valid/ready   code_unit, last, byte_count, truncated
//  i_cfg_*   in   write enable  buffer size in bytes (21 bits)
//
//  one word per cycle sustained unless the output stalls or the clearing
//  pass runs; a code unit is registered by the map RAM read, then by the
//  output register; after reset a clearing pass walks all 65536 map
//  entries, one per cycle; no input word is taken until the pass is done
//  a stalled output holds one result in the output register and one in the
//  lookup stage before the input side stalls
// ----------------------------------------------------------------------------
`default_nettype none

module sjis_to_utf16_decoder_core import sjd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    sjd_in_if.sink             i_in,
    sjd_out_if.source          o_out
);

    // configuration
    logic [COUNT_W-1:0] r_buf_bytes;

    // clearing pass
    logic              r_clearing;
    logic [KEY_W-1:0]  r_clr_addr;

    // string state
    logic [BYTE_W-1:0]  r_lead, n_lead;
    logic               r_lead_wait, n_lead_wait;
    logic [COUNT_W-1:0] r_used, n_used;
    logic               r_dropped, n_dropped;

    // lookup stage
    logic               r_s1_v, n_s1_v;
    logic               r_s1_term, n_s1_term;
    logic [COUNT_W-1:0] r_s1_count, n_s1_count;
    logic               r_s1_trunc, n_s1_trunc;

    // output register
    logic               r_out_v;
    logic [UNIT_W-1:0]  r_out_unit;
    logic               r_out_last;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_trunc;

    // ram ports
    logic               w_we;
    logic [KEY_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_re;
    logic [KEY_W-1:0]   w_raddr;
    logic [ENTRY_W-1:0] w_rdata;

    logic               w_acc;
    logic               w_s1_move;
    logic               w_fits;
    logic [COUNT_W:0]   w_need;
    logic [UNIT_W-1:0]  w_s1_unit;

    // handshakes
    assign w_s1_move  = r_s1_v && (!r_out_v || o_out.ready);
    assign i_in.ready = !r_clearing && (!r_s1_v || !r_out_v || o_out.ready);
    assign w_acc      = i_in.valid && i_in.ready;

    // room check for one more unit
    assign w_need = {1'b0, r_used} + {1'b0, UNIT_BYTES};
    assign w_fits = w_need <= {1'b0, r_buf_bytes};

    // decode step on the accepted word
    always_comb begin
        n_lead      = r_lead;
        n_lead_wait = r_lead_wait;
        n_used      = r_used;
        n_dropped   = r_dropped;
        n_s1_v      = w_s1_move ? 1'b0 : r_s1_v;
        n_s1_term   = r_s1_term;
        n_s1_count  = r_s1_count;
        n_s1_trunc  = r_s1_trunc;
        w_re        = 1'b0;
        w_raddr     = {{(KEY_W-BYTE_W){1'b0}}, i_in.in_byte};
        if (w_acc && i_in.operation == OP_CONVERT) begin
            if (i_in.in_byte == '0) begin
                // terminator, then fresh string
                n_s1_v      = 1'b1;
                n_s1_term   = 1'b1;
                n_s1_count  = r_used;
                n_s1_trunc  = r_dropped;
                n_lead      = '0;
                n_lead_wait = 1'b0;
                n_used      = UNIT_BYTES;
                n_dropped   = 1'b0;
            end else if (!r_lead_wait && is_lead(i_in.in_byte)) begin
                n_lead      = i_in.in_byte;
                n_lead_wait = 1'b1;
            end else begin
                // completed character: single byte or lead-trail pair
                if (r_lead_wait) begin
                    w_raddr = {r_lead, i_in.in_byte};
                end
                n_lead      = '0;
                n_lead_wait = 1'b0;
                if (w_fits) begin
                    w_re       = 1'b1;
                    n_used     = w_need[COUNT_W-1:0];
                    n_s1_v     = 1'b1;
                    n_s1_term  = 1'b0;
                    n_s1_count = '0;
                    n_s1_trunc = 1'b0;
                end else begin
                    n_dropped = 1'b1;
                end
            end
        end
    end

    // map writes: clearing pass or load word
    assign w_we    = r_clearing || (w_acc && i_in.operation == OP_LOAD);
    assign w_waddr = r_clearing ? r_clr_addr : i_in.map_key;
    assign w_wdata = r_clearing ? '0 : {1'b1, i_in.map_value};

    sjd_ram #(
        .ADDR_W (KEY_W),
        .DATA_W (ENTRY_W)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // unmapped entries give the white square
    assign w_s1_unit = w_rdata[ENTRY_W-1] ? w_rdata[UNIT_W-1:0] : UNKNOWN_UNIT;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes <= BUF_RESET;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_lead      <= '0;
            r_lead_wait <= 1'b0;
            r_used      <= UNIT_BYTES;
            r_dropped   <= 1'b0;
            r_s1_v      <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_buf_bytes <= i_cfg_wdata;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            r_lead      <= n_lead;
            r_lead_wait <= n_lead_wait;
            r_used      <= n_used;
            r_dropped   <= n_dropped;
            r_s1_v      <= n_s1_v;
            if (w_s1_move) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // lookup stage and output payload
    always_ff @(posedge i_clk) begin
        r_s1_term  <= n_s1_term;
        r_s1_count <= n_s1_count;
        r_s1_trunc <= n_s1_trunc;
        if (w_s1_move) begin
            r_out_unit  <= r_s1_term ? '0 : w_s1_unit;
            r_out_last  <= r_s1_term;
            r_out_count <= r_s1_count;
            r_out_trunc <= r_s1_trunc;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.code_unit  = r_out_unit;
    assign o_out.last       = r_out_last;
    assign o_out.byte_count = r_out_count;
    assign o_out.truncated  = r_out_trunc;

endmodule

`default_nettype wire

// File: hw/rtl/sjd_checker.sv
// ----------------------------------------------------------------------------
// sjd_checker
// Port-level checks on the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sjd_checker import sjd_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [UNIT_W-1:0]  i_code_unit,
    input wire logic               i_last,
    input wire logic [COUNT_W-1:0] i_byte_count,
    input wire logic               i_truncated
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_unit) &&
        $stable(i_last) && $stable(i_byte_count) && $stable(i_truncated))
        else $error("stalled output word changed");

    // terminator carries a zero unit
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> i_code_unit == '0)
        else $error("terminator with nonzero unit");

    // count and flag only on the terminator
    a_plain_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_byte_count == '0 && !i_truncated)
        else $error("count or flag on a plain unit");

    // count is even and covers the terminator
    a_count_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> !i_byte_count[0] && i_byte_count >= UNIT_BYTES)
        else $error("bad terminator byte count");

endmodule

bind sjis_to_utf16_decoder_core sjd_checker u_sjd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_code_unit  (o_out.code_unit),
    .i_last       (o_out.last),
    .i_byte_count (o_out.byte_count),
    .i_truncated  (o_out.truncated)
);

`default_nettype wire

// File: bench/sjis_to_utf16_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sjis_to_utf16_decoder_core_test
// Drives Shift-JIS strings and map loads into the decoder, predicts every
// code unit and terminator in step with accepted words, and checks each
// output word field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sjis_to_utf16_decoder_core_test;
    import sjd_pkg::*;

    typedef struct {
        t_op               op;
        logic [BYTE_W-1:0] in_byte;
        logic [KEY_W-1:0]  key;
        logic [UNIT_W-1:0] value;
    } t_word;

    typedef struct {
        logic [UNIT_W-1:0]  unit;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               trunc;
    } t_unit;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 1250;
    localparam int PHASES        = 6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;

    sjd_in_if  in_if ();
    sjd_out_if out_if ();

    sjis_to_utf16_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow decoder state
    logic [UNIT_W-1:0] map_unit [0:65535];
    bit                map_valid [0:65535];
    logic [BYTE_W-1:0] held_lead = '0;
    bit                lead_held = 1'b0;
    int unsigned       used_bytes = 2;
    bit                dropped = 1'b0;
    int unsigned       buf_size = 32'(BUF_RESET);

    t_word word_q [$];
    t_unit unit_q [$];
    t_word cur_word;
    int    send_idle_pct = 17;
    int    recv_idle_pct = 68;
    int    errors = 0;
    int    pushed = 0;

    function automatic bit lead_code(input logic [BYTE_W-1:0] b);
        return ((b >= LEAD_A_LO) && (b <= LEAD_A_HI)) || ((b >= LEAD_B_LO) && (b <= LEAD_B_HI));
    endfunction

    function automatic void reset_string();
        held_lead  = '0;
        lead_held  = 1'b0;
        used_bytes = 2;
        dropped    = 1'b0;
    endfunction

    // look a code up and emit it if it still fits the buffer
    function automatic void place_unit(input logic [KEY_W-1:0] code);
        t_unit u;
        if (used_bytes + 2 <= buf_size) begin
            used_bytes += 2;
            u.unit  = map_valid[code] ? map_unit[code] : UNKNOWN_UNIT;
            u.last  = 1'b0;
            u.count = '0;
            u.trunc = 1'b0;
            unit_q.push_back(u);
        end else begin
            dropped = 1'b1;
        end
    endfunction

    // expected code units caused by one accepted word
    function automatic void predict_units(input t_word w);
        t_unit u;
        if (w.op == OP_LOAD) begin
            map_unit[w.key]  = w.value;
            map_valid[w.key] = 1'b1;
        end else if (w.in_byte == '0) begin
            u.unit  = '0;
            u.last  = 1'b1;
            u.count = COUNT_W'(used_bytes);
            u.trunc = dropped;
            unit_q.push_back(u);
            reset_string();
        end else if (lead_held) begin
            lead_held = 1'b0;
            place_unit({held_lead, w.in_byte});
            held_lead = '0;
        end else if (lead_code(w.in_byte)) begin
            held_lead = w.in_byte;
            lead_held = 1'b1;
        end else begin
            place_unit({8'h00, w.in_byte});
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // input driver, fed from the pending word queue
    always @(posedge i_clk) begin : drive
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                predict_units(cur_word);
            if (!in_if.valid || in_if.ready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = word_q.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.operation <= cur_word.op;
                    in_if.in_byte   <= cur_word.in_byte;
                    in_if.map_key   <= cur_word.key;
                    in_if.map_value <= cur_word.value;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge i_clk) begin : watch
        t_unit want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (unit_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none actual unit %0h last %0b",
                             $time, out_if.code_unit, out_if.last);
                end else begin
                    want = unit_q.pop_front();
                    check_field("code_unit", 32'(want.unit), 32'(out_if.code_unit));
                    check_field("last", 32'(want.last), 32'(out_if.last));
                    check_field("byte_count", 32'(want.count), 32'(out_if.byte_count));
                    check_field("truncated", 32'(want.trunc), 32'(out_if.truncated));
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_word(input t_op op, input logic [BYTE_W-1:0] b,
                             input logic [KEY_W-1:0] key, input logic [UNIT_W-1:0] value);
        t_word w;
        w.op      = op;
        w.in_byte = b;
        w.key     = key;
        w.value   = value;
        word_q.push_back(w);
        pushed++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        push_word(OP_CONVERT, b, KEY_W'($urandom), UNIT_W'($urandom));
    endtask

    task automatic push_load(input logic [KEY_W-1:0] key, input logic [UNIT_W-1:0] value);
        push_word(OP_LOAD, BYTE_W'($urandom), key, value);
    endtask

    function automatic logic [BYTE_W-1:0] pick_lead();
        int r;
        r = $urandom_range(0, 59);
        return (r < 31) ? BYTE_W'(LEAD_A_LO + r) : BYTE_W'(LEAD_B_LO + r - 31);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_single();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(1, 255));
        while (lead_code(b));
        return b;
    endfunction

    // wait until nothing is in flight, then let the pipeline settle
    task automatic drain();
        do
            @(negedge i_clk);
        while (word_q.size() != 0 || in_if.valid || unit_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_buffer(input logic [COUNT_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        buf_size   = 32'(v);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        logic [KEY_W-1:0]   key_pool [0:31];
        logic [COUNT_W-1:0] buf_set [0:PHASES-1];
        logic [KEY_W-1:0]   code;
        int                 start;
        int                 r;

        in_if.valid     = 1'b0;
        in_if.operation = OP_CONVERT;
        in_if.in_byte   = '0;
        in_if.map_key   = '0;
        in_if.map_value = '0;
        out_if.ready    = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // mapped, unmapped, mapped-to-zero and both lead ranges at their edges
        push_load(16'h0041, 16'h0041);
        push_load(16'h8140, 16'h3000);
        push_load(16'hFFFF, 16'hFFFF);
        push_load(16'h00FF, 16'h0000);
        push_load(16'h9FFC, 16'hABCD);
        push_load(16'hE040, 16'h5555);
        push_byte(8'h41);
        push_byte(8'h42);
        push_byte(8'hFF);
        push_byte(8'h81); push_byte(8'h40);
        push_byte(8'h9F); push_byte(8'hFC);
        push_byte(8'hE0); push_byte(8'h40);
        push_byte(8'hFC); push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'hA0);
        push_byte(8'hDF);
        push_byte(8'hFD);
        push_byte(8'h00);
        // load right before use, overwrite, zero after a lead, empty string
        push_load(16'h0043, 16'h7777);
        push_byte(8'h43);
        push_load(16'h0041, 16'h0061);
        push_byte(8'h41);
        push_byte(8'h81); push_byte(8'h00);
        push_byte(8'h00);
        drain();

        // tiny buffers: everything dropped, lead still eats its trail
        write_buffer(21'd2);
        push_byte(8'h81); push_byte(8'h40); push_byte(8'h41); push_byte(8'h00);
        drain();
        write_buffer(21'd1);
        push_byte(8'h41); push_byte(8'h00);
        drain();
        write_buffer(21'd0);
        push_byte(8'h42); push_byte(8'h00);
        drain();
        // odd buffer: two units fit, the rest is dropped
        write_buffer(21'd7);
        push_byte(8'h41); push_byte(8'h42); push_byte(8'h81); push_byte(8'h40);
        push_byte(8'h43); push_byte(8'h00);
        drain();

        // codes that strings reuse so that lookups often hit loaded entries
        foreach (key_pool[i])
            key_pool[i] = (i % 2) ? {pick_lead(), BYTE_W'($urandom_range(1, 255))}
                                  : {8'h00, pick_single()};

        buf_set[0] = BUF_RESET;
        buf_set[1] = COUNT_W'(2 * $urandom_range(2, 12));
        buf_set[2] = COUNT_W'(2 * $urandom_range(1, 10) + 1);
        buf_set[3] = 21'd2;
        buf_set[4] = 21'h1FFFFF;
        buf_set[5] = COUNT_W'($urandom_range(2, 1048576));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_buffer(buf_set[p]);
            send_idle_pct = (p < 2) ? 17 : (p < 4) ? 68 : 0;
            recv_idle_pct = (p < 2) ? 68 : (p < 4) ? 17 : 0;
            start = pushed;
            while (pushed - start < RANDOM_WORDS / PHASES) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    push_load(($urandom_range(9) < 7) ? key_pool[$urandom_range(31)]
                                                      : KEY_W'($urandom),
                              ($urandom_range(9) == 0) ? '0 : UNIT_W'($urandom));
                end else if (r < 15) begin
                    push_byte(BYTE_W'($urandom_range(0, 255)));
                end else if (r < 18) begin
                    push_byte(pick_lead());
                    push_byte(8'h00);
                end else begin
                    // well-formed string of singles and pairs, zero terminated
                    repeat ($urandom_range(0, 10)) begin
                        if ($urandom_range(1))
                            code = key_pool[$urandom_range(31)];
                        else if ($urandom_range(2) == 0)
                            code = {pick_lead(), BYTE_W'($urandom_range(1, 255))};
                        else
                            code = {8'h00, pick_single()};
                        if (code[15:8] != '0)
                            push_byte(code[15:8]);
                        push_byte(code[7:0]);
                    end
                    push_byte(8'h00);
                end
            end
        end

        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit, covers the map clearing pass after reset
    initial begin
        #(12_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
